[rtl/ifc_pkg.sv]
package ifc_pkg;

	// verdict codes
	typedef enum logic [1:0] {
		VERDICT_PASS    = 2'd0,
		VERDICT_REQUEST = 2'd1,
		VERDICT_STATS   = 2'd2,
		VERDICT_ARP     = 2'd3
	} verdict_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_OWN_IP    = 2'd0,
		CFG_OWN_MAC   = 2'd1,
		CFG_REQ_PORT  = 2'd2,
		CFG_STAT_PORT = 2'd3
	} cfg_index_t;

	localparam logic [31:0] OWN_IP_RESET    = (32'd10 << 24) | (32'd0 << 16) | (32'd0 << 8) | 32'd2;
	localparam logic [15:0] REQ_PORT_RESET  = 16'd15712;
	localparam logic [15:0] STAT_PORT_RESET = REQ_PORT_RESET + 16'd1;

	localparam logic [15:0] ETH_TYPE_IPV4 = {8'h08, 8'h00};
	localparam logic [15:0] ETH_TYPE_ARP  = {8'h08, 8'h06};
	localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
	localparam logic [15:0] ARP_OP_REQ    = 16'd1;

	localparam int IFC_QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [31:0] own_ip;
		logic [15:0] req_port;
		logic [15:0] stat_port;
	} ifc_cfg_t;

	// one classified frame, passed from the parser to the result stage
	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] ip_src;
		logic [31:0] arp_ip;
		logic [15:0] udp_sport;
		logic [3:0]  ihl;
		logic [15:0] udp_len;
		logic [47:0] src_mac;
		logic [47:0] arp_hw;
		logic [31:0] frame_count;
	} ifc_rec_t;

endpackage

[rtl/ingress_frame_classifier.sv]
// Ingress frame classifier: Ethernet / IPv4 / UDP / ARP.
// Ingress channel: one frame byte per request (frame_byte, frame_end on the
// last byte), valid/ready. One byte is taken every cycle while the internal
// queue has room; frames are back to back with no gap needed.
// Result channel: one request per frame, issued for its last byte, with the
// verdict (pass, memory request, statistics request, ARP reply), the peer
// addresses, UDP payload offset/length and the running IPv4 frame count.
// Result path: the parser pushes the record into the queue when the last
// byte is accepted; the output register takes it when empty or read.
// Throughput: one byte per cycle, set by the byte-wide parser; one result
// per frame, which needs at least one byte, so results never outpace bytes.
// Stall: if result_ready stays low, finished frames wait in the queue
// (QUEUE_DEPTH entries plus the output register); ingress_ready drops only
// once the queue is full, so bytes keep flowing for several short frames.
// Reset: arst_n clears the parser, frame counter, queue and output valid;
// the configuration registers return to their defaults (10.0.0.2, ports
// 15712 / 15713). Configuration is written through cfg_we / cfg_index /
// cfg_wdata, one register per cycle, and takes effect at once.
module ingress_frame_classifier #(
	parameter int QUEUE_DEPTH = ifc_pkg::IFC_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	input  logic        ingress_valid,
	output logic        ingress_ready,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  verdict,
	output logic [31:0] peer_ip,
	output logic [15:0] peer_port,
	output logic [6:0]  payload_offset,
	output logic [15:0] payload_length,
	output logic [47:0] peer_mac,
	output logic [47:0] requester_hw_addr,
	output logic [31:0] ipv4_frames_seen
);
	import ifc_pkg::*;

	logic [31:0] own_ip_q;
	logic [15:0] req_port_q;
	logic [15:0] stat_port_q;
	ifc_cfg_t    cfg;

	logic        accept;
	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_valid;
	ifc_rec_t    q_wr;
	ifc_rec_t    q_rd;

	// config registers; writes to the own MAC index are ignored here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q    <= OWN_IP_RESET;
			req_port_q  <= REQ_PORT_RESET;
			stat_port_q <= STAT_PORT_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_OWN_IP:    own_ip_q    <= cfg_wdata[31:0];
				CFG_REQ_PORT:  req_port_q  <= cfg_wdata[15:0];
				CFG_STAT_PORT: stat_port_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.own_ip    = own_ip_q;
		cfg.req_port  = req_port_q;
		cfg.stat_port = stat_port_q;
	end

	// front: byte parser and classifier
	assign ingress_ready = !q_full;
	assign accept        = ingress_valid && ingress_ready;

	ifc_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (accept),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.rec_push   (q_push),
		.rec        (q_wr)
	);

	// decoupling queue between classifier and result stage
	ifc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_data  (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_rd)
	);

	// back: result forming and output register
	ifc_emit u_emit (
		.clk               (clk),
		.arst_n            (arst_n),
		.rec_valid         (q_valid),
		.rec               (q_rd),
		.rec_pop           (q_pop),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.verdict           (verdict),
		.peer_ip           (peer_ip),
		.peer_port         (peer_port),
		.payload_offset    (payload_offset),
		.payload_length    (payload_length),
		.peer_mac          (peer_mac),
		.requester_hw_addr (requester_hw_addr),
		.ipv4_frames_seen  (ipv4_frames_seen)
	);

endmodule

[rtl/ifc_parser.sv]
module ifc_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  ifc_pkg::ifc_cfg_t cfg,
	input  logic            accept,
	input  logic [7:0]      frame_byte,
	input  logic            frame_end,
	output logic            rec_push,
	output ifc_pkg::ifc_rec_t rec
);
	import ifc_pkg::*;

	localparam logic [6:0] POS_MAX = 7'd127;

	logic [6:0]  pos_q;
	logic [15:0] eth_q, eth_d;
	logic [47:0] src_mac_q, src_mac_d;
	logic [3:0]  ihl_q, ihl_d;
	logic [7:0]  proto_q, proto_d;
	logic [31:0] ip_src_q, ip_src_d;
	logic [31:0] ip_dst_q, ip_dst_d;
	logic [15:0] sport_q, sport_d;
	logic [15:0] dport_q, dport_d;
	logic [15:0] ulen_q, ulen_d;
	logic [15:0] arp_op_q, arp_op_d;
	logic [47:0] arp_hw_q, arp_hw_d;
	logic [31:0] arp_ip_q, arp_ip_d;
	logic [31:0] arp_tip_q, arp_tip_d;
	logic [31:0] count_q, count_next;

	logic [6:0] base;
	logic [6:0] rel;
	logic       in_udp;
	logic       is_ipv4;
	logic       udp_ok;
	verdict_t   verdict;

	always_comb begin
		ihl_d     = (pos_q == 7'd14) ? frame_byte[3:0] : ihl_q;
		base      = 7'd14 + {1'b0, ihl_d, 2'b00};
		in_udp    = (pos_q >= base) && (pos_q < base + 7'd8);
		rel       = pos_q - base;

		eth_d     = eth_q;
		src_mac_d = src_mac_q;
		proto_d   = proto_q;
		ip_src_d  = ip_src_q;
		ip_dst_d  = ip_dst_q;
		sport_d   = sport_q;
		dport_d   = dport_q;
		ulen_d    = ulen_q;
		arp_op_d  = arp_op_q;
		arp_hw_d  = arp_hw_q;
		arp_ip_d  = arp_ip_q;
		arp_tip_d = arp_tip_q;

		if (pos_q >= 7'd6 && pos_q <= 7'd11) src_mac_d = {src_mac_q[39:0], frame_byte};
		if (pos_q == 7'd12 || pos_q == 7'd13) eth_d = {eth_q[7:0], frame_byte};
		if (pos_q == 7'd23) proto_d = frame_byte;
		if (pos_q >= 7'd26 && pos_q <= 7'd29) ip_src_d = {ip_src_q[23:0], frame_byte};
		if (pos_q >= 7'd30 && pos_q <= 7'd33) ip_dst_d = {ip_dst_q[23:0], frame_byte};
		if (pos_q == 7'd20 || pos_q == 7'd21) arp_op_d = {arp_op_q[7:0], frame_byte};
		if (pos_q >= 7'd22 && pos_q <= 7'd27) arp_hw_d = {arp_hw_q[39:0], frame_byte};
		if (pos_q >= 7'd28 && pos_q <= 7'd31) arp_ip_d = {arp_ip_q[23:0], frame_byte};
		if (pos_q >= 7'd38 && pos_q <= 7'd41) arp_tip_d = {arp_tip_q[23:0], frame_byte};
		if (in_udp) begin
			case (rel[2:1])
				2'd0: sport_d = {sport_q[7:0], frame_byte};
				2'd1: dport_d = {dport_q[7:0], frame_byte};
				2'd2: ulen_d  = {ulen_q[7:0], frame_byte};
				default: ;
			endcase
		end

		// frame length is pos_q + 1, so each length test is one less here
		is_ipv4 = (pos_q >= 7'd13) && (eth_d == ETH_TYPE_IPV4);
		udp_ok  = (pos_q >= 7'd33) && (pos_q >= base + 7'd7) &&
			(ip_dst_d == cfg.own_ip) && (proto_d == IP_PROTO_UDP);

		verdict = VERDICT_PASS;
		if (is_ipv4) begin
			if (udp_ok && dport_d == cfg.req_port) verdict = VERDICT_REQUEST;
			else if (udp_ok && dport_d == cfg.stat_port) verdict = VERDICT_STATS;
		end else if (pos_q >= 7'd41 && eth_d == ETH_TYPE_ARP &&
			arp_op_d == ARP_OP_REQ && arp_tip_d == cfg.own_ip) begin
			verdict = VERDICT_ARP;
		end

		count_next = is_ipv4 ? count_q + 32'd1 : count_q;
	end

	assign rec_push = accept && frame_end;

	always_comb begin
		rec.verdict     = verdict;
		rec.ip_src      = ip_src_d;
		rec.arp_ip      = arp_ip_d;
		rec.udp_sport   = sport_d;
		rec.ihl         = ihl_d;
		rec.udp_len     = ulen_d;
		rec.src_mac     = src_mac_d;
		rec.arp_hw      = arp_hw_d;
		rec.frame_count = count_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			eth_q     <= '0;
			src_mac_q <= '0;
			ihl_q     <= '0;
			proto_q   <= '0;
			ip_src_q  <= '0;
			ip_dst_q  <= '0;
			sport_q   <= '0;
			dport_q   <= '0;
			ulen_q    <= '0;
			arp_op_q  <= '0;
			arp_hw_q  <= '0;
			arp_ip_q  <= '0;
			arp_tip_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q     <= '0;
				eth_q     <= '0;
				src_mac_q <= '0;
				ihl_q     <= '0;
				proto_q   <= '0;
				ip_src_q  <= '0;
				ip_dst_q  <= '0;
				sport_q   <= '0;
				dport_q   <= '0;
				ulen_q    <= '0;
				arp_op_q  <= '0;
				arp_hw_q  <= '0;
				arp_ip_q  <= '0;
				arp_tip_q <= '0;
				count_q   <= count_next;
			end else begin
				pos_q     <= (pos_q != POS_MAX) ? pos_q + 7'd1 : pos_q;
				eth_q     <= eth_d;
				src_mac_q <= src_mac_d;
				ihl_q     <= ihl_d;
				proto_q   <= proto_d;
				ip_src_q  <= ip_src_d;
				ip_dst_q  <= ip_dst_d;
				sport_q   <= sport_d;
				dport_q   <= dport_d;
				ulen_q    <= ulen_d;
				arp_op_q  <= arp_op_d;
				arp_hw_q  <= arp_hw_d;
				arp_ip_q  <= arp_ip_d;
				arp_tip_q <= arp_tip_d;
			end
		end
	end

endmodule

[rtl/ifc_queue.sv]
module ifc_queue #(
	parameter int DEPTH = ifc_pkg::IFC_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ifc_pkg::ifc_rec_t wr_data,
	output logic            full,
	input  logic            pop,
	output logic            rd_valid,
	output ifc_pkg::ifc_rec_t rd_data
);
	import ifc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ifc_rec_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!rd_valid |-> !pop)
		else $error("pop from empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill count lost a push");

endmodule

[rtl/ifc_emit.sv]
module ifc_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rec_valid,
	input  ifc_pkg::ifc_rec_t rec,
	output logic            rec_pop,
	output logic            result_valid,
	input  logic            result_ready,
	output logic [1:0]      verdict,
	output logic [31:0]     peer_ip,
	output logic [15:0]     peer_port,
	output logic [6:0]      payload_offset,
	output logic [15:0]     payload_length,
	output logic [47:0]     peer_mac,
	output logic [47:0]     requester_hw_addr,
	output logic [31:0]     ipv4_frames_seen
);
	import ifc_pkg::*;

	logic        valid_q;
	logic        load;
	logic        is_udp;
	logic        is_arp;
	verdict_t    verdict_q;
	logic [31:0] peer_ip_q;
	logic [15:0] peer_port_q;
	logic [6:0]  poff_q;
	logic [15:0] plen_q;
	logic [47:0] peer_mac_q;
	logic [47:0] req_hw_q;
	logic [31:0] count_q;

	assign load    = rec_valid && (!valid_q || result_ready);
	assign rec_pop = load;
	assign is_udp  = (rec.verdict == VERDICT_REQUEST) || (rec.verdict == VERDICT_STATS);
	assign is_arp  = (rec.verdict == VERDICT_ARP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q   <= rec.verdict;
			peer_ip_q   <= is_udp ? rec.ip_src : (is_arp ? rec.arp_ip : '0);
			peer_port_q <= is_udp ? rec.udp_sport : '0;
			poff_q      <= is_udp ? 7'd22 + {1'b0, rec.ihl, 2'b00} : '0;
			plen_q      <= (is_udp && rec.udp_len >= 16'd8) ? rec.udp_len - 16'd8 : '0;
			peer_mac_q  <= rec.src_mac;
			req_hw_q    <= is_arp ? rec.arp_hw : '0;
			count_q     <= rec.frame_count;
		end
	end

	assign result_valid      = valid_q;
	assign verdict           = verdict_q;
	assign peer_ip           = peer_ip_q;
	assign peer_port         = peer_port_q;
	assign payload_offset    = poff_q;
	assign payload_length    = plen_q;
	assign peer_mac          = peer_mac_q;
	assign requester_hw_addr = req_hw_q;
	assign ipv4_frames_seen  = count_q;

	a_pass_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && verdict_q == VERDICT_PASS) |->
		(peer_ip_q == '0 && peer_port_q == '0 && req_hw_q == '0))
		else $error("pass verdict carries peer fields");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_ready) |-> !load)
		else $error("result overwritten while stalled");

endmodule
